/* rtl/pal_pkg.sv */
// Package with the shared constants, codes and transfer types of the positional array list.
package pal_pkg;

  localparam int CAPACITY = 128;
  localparam int AddrW    = $clog2(CAPACITY);
  localparam int CntW     = $clog2(CAPACITY + 1);
  localparam int CmpW     = ((CntW > 8) ? CntW : 8) + 1;
  localparam int DataW    = 32;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_READ   = 3'd4
  } pal_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } pal_status_e;

  typedef struct packed {
    logic [2:0]               operation;
    logic [7:0]               position;
    logic signed [DataW-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0]  data_out;
    logic [7:0]               count_after;
    pal_status_e              status;
  } out_item_t;

  // One write port and one read port toward the entry store.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

/* rtl/pal_store.sv */
// Entry store: synchronous memory with one write port and one registered read port.
module pal_store (
  input  logic                       clk_i,
  input  pal_pkg::mem_req_t          req_i,
  output logic [pal_pkg::DataW-1:0]  rdata_o
);
  import pal_pkg::*;

  logic [DataW-1:0] mem [CAPACITY];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pal_ctrl.sv */
// Request sequencer: checks each request and walks the entry store to shift, read or write.
module pal_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  pal_pkg::in_item_t          in_item_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output pal_pkg::out_item_t         res_o,
  output pal_pkg::mem_req_t          mem_req_o,
  input  logic [pal_pkg::DataW-1:0]  mem_rdata_i
);
  import pal_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_LOOKUP   = 7'b0000010,
    S_TAKE     = 7'b0000100,
    S_SHIFT_UP = 7'b0001000,
    S_SHIFT_DN = 7'b0010000,
    S_PLACE    = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  n_q, n_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [DataW-1:0] val_q, val_d;
  logic [DataW-1:0] data_q, data_d;
  pal_status_e      status_q, status_d;

  logic [CmpW-1:0]  pos_w;
  logic [CmpW-1:0]  cnt_w;
  logic [AddrW-1:0] k_w;
  logic             full_w;
  logic             empty_w;
  logic             ins_ok_w;
  logic             pos_ok_w;

  assign pos_w    = CmpW'(in_item_i.position);
  assign cnt_w    = CmpW'(count_q);
  assign k_w      = AddrW'(pos_w - CmpW'(1));
  assign full_w   = (cnt_w >= CmpW'(CAPACITY));
  assign empty_w  = (count_q == '0);
  assign ins_ok_w = (pos_w >= CmpW'(1)) && (pos_w <= cnt_w + CmpW'(1));
  assign pos_ok_w = (pos_w >= CmpW'(1)) && (pos_w <= cnt_w);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    n_d       = n_q;
    idx_d     = idx_q;
    ptr_d     = ptr_q;
    val_d     = val_q;
    data_d    = data_q;
    status_d  = status_q;
    mem_req_o = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          data_d   = '0;
          status_d = ST_OK;
          state_d  = S_DONE;
          case (pal_op_e'(in_item_i.operation))
            OP_APPEND: begin
              if (full_w) begin
                status_d = ST_FULL;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = AddrW'(count_q);
                mem_req_o.wdata = in_item_i.value;
                count_d         = count_q + CntW'(1);
              end
            end
            OP_POP: begin
              if (empty_w) begin
                status_d = ST_EMPTY;
              end else begin
                count_d         = count_q - CntW'(1);
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = AddrW'(count_q - CntW'(1));
                state_d         = S_LOOKUP;
              end
            end
            OP_INSERT: begin
              if (full_w) begin
                status_d = ST_FULL;
              end else if (!ins_ok_w) begin
                status_d = ST_RANGE;
              end else begin
                count_d = count_q + CntW'(1);
                val_d   = in_item_i.value;
                idx_d   = k_w;
                if (pos_w == cnt_w + CmpW'(1)) begin
                  // Insertion at the tail needs no shift.
                  mem_req_o.we    = 1'b1;
                  mem_req_o.waddr = k_w;
                  mem_req_o.wdata = in_item_i.value;
                end else begin
                  mem_req_o.re    = 1'b1;
                  mem_req_o.raddr = AddrW'(count_q - CntW'(1));
                  ptr_d           = AddrW'(count_q);
                  state_d         = S_SHIFT_UP;
                end
              end
            end
            OP_REMOVE: begin
              if (empty_w) begin
                status_d = ST_EMPTY;
              end else if (!pos_ok_w) begin
                status_d = ST_RANGE;
              end else begin
                n_d             = count_q;
                count_d         = count_q - CntW'(1);
                idx_d           = k_w;
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = k_w;
                state_d         = S_TAKE;
              end
            end
            OP_READ: begin
              if (empty_w) begin
                status_d = ST_EMPTY;
              end else if (!pos_ok_w) begin
                status_d = ST_RANGE;
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = k_w;
                state_d         = S_LOOKUP;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_LOOKUP: begin
        data_d  = mem_rdata_i;
        state_d = S_DONE;
      end
      S_TAKE: begin
        data_d = mem_rdata_i;
        if (CntW'(idx_q) + CntW'(1) < n_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = idx_q + AddrW'(1);
          ptr_d           = idx_q + AddrW'(1);
          state_d         = S_SHIFT_DN;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SHIFT_UP: begin
        // The read data came from the entry just below the write pointer.
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ptr_q;
        mem_req_o.wdata = mem_rdata_i;
        if (ptr_q - AddrW'(1) == idx_q) begin
          state_d = S_PLACE;
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ptr_q - AddrW'(2);
          ptr_d           = ptr_q - AddrW'(1);
        end
      end
      S_SHIFT_DN: begin
        // The read data came from the pointer entry and moves one place down.
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ptr_q - AddrW'(1);
        mem_req_o.wdata = mem_rdata_i;
        if (CntW'(ptr_q) + CntW'(1) < n_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ptr_q + AddrW'(1);
          ptr_d           = ptr_q + AddrW'(1);
        end else begin
          state_d = S_DONE;
        end
      end
      S_PLACE: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q;
        mem_req_o.wdata = val_q;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    idx_q    <= idx_d;
    ptr_q    <= ptr_d;
    val_q    <= val_d;
    data_q   <= data_d;
    status_q <= status_d;
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.data_out    = data_q;
  assign res_o.count_after = 8'(count_q);
  assign res_o.status      = status_q;

endmodule

/* rtl/positional_array_list.sv */
// Top level of the positional array list: sequencer, entry store and output register.
//
// An ordered list of signed 32-bit values kept in a 128-entry synchronous memory
// with a used count. Each request on the input channel appends, removes the last
// value, inserts at a one-based position, removes at a position or reads one
// position, and yields exactly one result transfer on the output channel with
// the removed or read value, the count after the request and a status code.
// Both channels move one transfer at an edge where valid is high and stall low.
// Append, errors and unused codes set the result directly; pop and read first wait
// for the registered memory read. Insert at position p of a list of n entries
// shifts n-p+1 entries up one per cycle through the single write port and then
// writes the new value, except that an insert just past the tail writes directly;
// remove at p reads the value and shifts the entries after it down one place.
// The next request is taken once the previous one has handed its result to the
// output register, so requests never overlap. A stalled result waits in the
// output register; the sequencer holds a second finished result until the
// register frees, and the input stalls meanwhile. Reset empties the list at
// once; the memory itself is not cleared, since no legal request reads an entry
// that was never written.
module positional_array_list (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pal_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pal_pkg::out_item_t  out_item_o
);
  import pal_pkg::*;

  mem_req_t         mem_req;
  logic [DataW-1:0] mem_rdata;
  logic             res_valid;
  logic             res_ready;
  out_item_t        res;

  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q, out_item_d;

  pal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  pal_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // The output register is free when empty or when its transfer completes now.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_item_d  = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* test/tb_positional_array_list.sv */
// Self-checking testbench for the positional array list with a scoreboard class and random traffic.
module tb_positional_array_list;
  timeunit 1ns;
  timeprecision 1ps;

  import pal_pkg::*;

  // The slowest correct run is about 1250 requests, each of which may shift the whole list,
  // plus the longest sender gap and receiver stall per request and one long hold-off.
  // The limit leaves a wide margin over that.
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = CAPACITY + 8;
  localparam int PRINT_CAP     = 100;

  // The scoreboard keeps its own copy of the list. Every request accepted on the input
  // side is applied to that copy, and the result it should produce is queued. Results
  // from the block are then matched in order against the oldest queued entry.
  class list_scoreboard;
    logic signed [DataW-1:0] entries [CAPACITY];
    int unsigned             used;
    int unsigned             deepest;
    out_item_t               expected_q [$];
    int unsigned             errors;
    int unsigned             requests;
    int unsigned             results;
    int unsigned             status_hits [4];

    function new();
      used     = 0;
      deepest  = 0;
      errors   = 0;
      requests = 0;
      results  = 0;
      foreach (status_hits[s]) status_hits[s] = 0;
    endfunction

    // Prints one line per mismatch, up to a cap, and counts all of them.
    task report(input string msg);
      if (errors < PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    // Applies one accepted request to the local list and queues the result it causes.
    function void note_request(input in_item_t req);
      out_item_t   exp;
      int unsigned pos;
      int unsigned i;
      exp        = '0;
      exp.status = ST_OK;
      pos        = req.position;
      case (req.operation)
        OP_APPEND: begin
          if (used >= CAPACITY) begin
            exp.status = ST_FULL;
          end else begin
            entries[used] = req.value;
            used++;
          end
        end
        OP_POP: begin
          if (used == 0) begin
            exp.status = ST_EMPTY;
          end else begin
            used--;
            exp.data_out = entries[used];
          end
        end
        OP_INSERT: begin
          // A full list is reported before the position is looked at.
          if (used >= CAPACITY) begin
            exp.status = ST_FULL;
          end else if (pos < 1 || pos > used + 1) begin
            exp.status = ST_RANGE;
          end else begin
            for (i = used; i > pos - 1; i--) entries[i] = entries[i - 1];
            entries[pos - 1] = req.value;
            used++;
          end
        end
        OP_REMOVE: begin
          if (used == 0) begin
            exp.status = ST_EMPTY;
          end else if (pos < 1 || pos > used) begin
            exp.status = ST_RANGE;
          end else begin
            exp.data_out = entries[pos - 1];
            for (i = pos - 1; i + 1 < used; i++) entries[i] = entries[i + 1];
            used--;
          end
        end
        OP_READ: begin
          if (used == 0) begin
            exp.status = ST_EMPTY;
          end else if (pos < 1 || pos > used) begin
            exp.status = ST_RANGE;
          end else begin
            exp.data_out = entries[pos - 1];
          end
        end
        default: begin
        end
      endcase
      exp.count_after = 8'(used);
      status_hits[exp.status]++;
      if (used > deepest) deepest = used;
      requests++;
      expected_q.push_back(exp);
    endfunction

    // Compares one accepted result, field by field, with the oldest expectation.
    task check_result(input out_item_t got);
      out_item_t exp;
      results++;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending: data %0d count %0d status %0d",
                         got.data_out, got.count_after, got.status));
      end else begin
        exp = expected_q.pop_front();
        if (got.data_out !== exp.data_out)
          report($sformatf("result %0d data_out %0d, expected %0d",
                           results, got.data_out, exp.data_out));
        if (got.count_after !== exp.count_after)
          report($sformatf("result %0d count_after %0d, expected %0d",
                           results, got.count_after, exp.count_after));
        if (got.status !== exp.status)
          report($sformatf("result %0d status %0d, expected %0d",
                           results, got.status, exp.status));
      end
    endtask
  endclass

  logic           clk         = 1'b0;
  logic           rst_n       = 1'b0;
  logic           req_valid   = 1'b0;
  logic           req_stall;
  in_item_t       req_item    = '0;
  logic           rsp_valid;
  logic           rsp_stall   = 1'b0;
  out_item_t      rsp_item;

  // While calm is set, the sender inserts no gaps and the receiver starts no new stall runs.
  logic           calm        = 1'b0;
  // The stimulus asks for a long receiver hold-off by bumping holds_asked.
  int unsigned    holds_asked = 0;
  int unsigned    holds_done  = 0;
  int unsigned    cycle_count = 0;

  list_scoreboard sb;

  positional_array_list uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .in_item_i   (req_item),
    .out_valid_o (rsp_valid),
    .out_stall_i (rsp_stall),
    .out_item_o  (rsp_item)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog: a correct run ends well before this many cycles.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout: run still busy after %0d cycles", cycle_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Sender gaps: mostly back to back or short, now and then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Values lean toward the signed extremes, zero and minus one.
  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Picks a one-based position for a list whose highest legal position is top.
  // Most picks are legal; the rest land on the edges, one past them, or anywhere.
  function automatic int unsigned pick_position(input int unsigned top);
    int unsigned r;
    r = $urandom_range(99);
    if (top == 0 || r < 8) return $urandom_range(CAPACITY, 1);
    if (r < 14) return (top < CAPACITY) ? top + 1 : $urandom_range(CAPACITY, 1);
    if (r < 20) return top;
    if (r < 26) return 1;
    return $urandom_range(top, 1);
  endfunction

  function automatic in_item_t make_item(input pal_op_e op, input int unsigned pos,
                                         input logic [DataW-1:0] val);
    in_item_t it;
    it.operation = op;
    it.position  = 8'(pos);
    it.value     = val;
    return it;
  endfunction

  // One random request. grow_pct sets how often the list is grown, which steers
  // the list toward full or toward empty over a phase.
  function automatic in_item_t random_request(input int unsigned grow_pct);
    int unsigned r;
    int unsigned n;
    pal_op_e     op;
    n = sb.used;
    r = $urandom_range(99);
    if (r < grow_pct) begin
      op = $urandom_range(1) ? OP_INSERT : OP_APPEND;
    end else begin
      r = $urandom_range(99);
      if (r < 35) op = OP_POP;
      else if (r < 70) op = OP_REMOVE;
      else op = OP_READ;
    end
    if (op == OP_INSERT)
      return make_item(op, pick_position((n < CAPACITY) ? n + 1 : CAPACITY), pick_value());
    return make_item(op, pick_position(n), pick_value());
  endfunction

  // Offers one request and waits for its transfer. Valid is lowered only when a gap
  // follows, so back-to-back requests keep it high without a glitch in one step.
  task automatic send_request(input in_item_t req);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_item  <= req;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(req);
  endtask

  // Receiver: checks each result transfer, then decides the stall for the next cycle.
  // Stalls come in runs; a requested hold-off keeps the stall high for HOLD_CYCLES.
  initial begin
    int unsigned run_left;
    int unsigned hold_left;
    int unsigned r;
    logic        stall_run;
    logic        next_stall;
    run_left  = 0;
    hold_left = 0;
    stall_run = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_valid && !rsp_stall) sb.check_result(rsp_item);
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(99);
          if (calm || r < 60) begin
            stall_run = 1'b0;
            run_left  = calm ? 7 : $urandom_range(12, 1);
          end else if (r < 92) begin
            stall_run = 1'b1;
            run_left  = $urandom_range(2);
          end else begin
            stall_run = 1'b1;
            run_left  = $urandom_range(40, 10);
          end
        end else begin
          run_left--;
        end
        next_stall = stall_run;
      end
      rsp_stall <= next_stall;
    end
  end

  // Stimulus: reset, a directed walk through the special cases, then random phases.
  initial begin
    int unsigned round;
    int unsigned phase;
    int unsigned k;
    int unsigned grow_pct;
    int unsigned phase_len;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every request on an empty list fails, and an insert beyond position one does too.
    send_request(make_item(OP_POP,    1,   32'h0));
    send_request(make_item(OP_REMOVE, 1,   32'h0));
    send_request(make_item(OP_READ,   128, 32'h0));
    send_request(make_item(OP_INSERT, 2,   32'h1111_1111));
    // Build a short list from the value extremes.
    send_request(make_item(OP_INSERT, 1,   32'h7fff_ffff));
    send_request(make_item(OP_APPEND, 1,   32'h8000_0000));
    send_request(make_item(OP_APPEND, 1,   32'h0000_0000));
    send_request(make_item(OP_APPEND, 1,   32'hffff_ffff));
    send_request(make_item(OP_READ,   1,   32'h0));
    send_request(make_item(OP_READ,   4,   32'h0));
    send_request(make_item(OP_READ,   5,   32'h0));
    // Insert at the front, just past the end, and in the middle; then one too far.
    send_request(make_item(OP_INSERT, 1,   32'h1234_5678));
    send_request(make_item(OP_INSERT, 6,   32'h0f0f_0f0f));
    send_request(make_item(OP_INSERT, 3,   32'ha5a5_a5a5));
    send_request(make_item(OP_INSERT, 9,   32'h5a5a_5a5a));
    // Remove at the front and at the end, then past the end.
    send_request(make_item(OP_REMOVE, 1,   32'h0));
    send_request(make_item(OP_REMOVE, 6,   32'h0));
    send_request(make_item(OP_REMOVE, 6,   32'h0));
    send_request(make_item(OP_READ,   128, 32'h0));
    send_request(make_item(OP_REMOVE, 3,   32'h0));
    send_request(make_item(OP_POP,    200, 32'h0));
    send_request(make_item(OP_READ,   2,   32'h0));

    // Random part: each round grows the list to full, churns it in the middle, and
    // drains it to empty, so the full and empty errors both get plenty of hits.
    for (round = 0; round < 2; round++) begin
      for (phase = 0; phase < 3; phase++) begin
        case (phase)
          0:       begin grow_pct = 95; phase_len = 220; end
          1:       begin grow_pct = 55; phase_len = 180; end
          default: begin grow_pct = 8;  phase_len = 200; end
        endcase
        for (k = 0; k < phase_len; k++) begin
          if (k % 40 == 0) calm <= ($urandom_range(3) == 0);
          // Once, early in the second round, the receiver holds off for a long
          // stretch while requests keep coming, so the block backs up into its input.
          if (round == 1 && phase == 0 && k == 5) holds_asked <= holds_asked + 1;
          send_request(random_request(grow_pct));
        end
      end
    end

    req_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    // Any stray result would show up in this window as one with nothing pending.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.expected_q.size()));

    $display("Checked %0d requests and %0d results; the list reached %0d of %0d entries.",
             sb.requests, sb.results, sb.deepest, CAPACITY);
    $display("Statuses ok/full/empty/range: %0d/%0d/%0d/%0d; one receiver hold of %0d cycles.",
             sb.status_hits[ST_OK], sb.status_hits[ST_FULL], sb.status_hits[ST_EMPTY],
             sb.status_hits[ST_RANGE], HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/pal_pkg.sv
rtl/pal_store.sv
rtl/pal_ctrl.sv
rtl/positional_array_list.sv
test/tb_positional_array_list.sv
